// ===== hw/rtl/rpr_pkg.sv =====
package rpr_pkg;

	// register file geometry
	localparam int REG_COUNT = 256;
	localparam int RF_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 3;

	// length byte carried by every response
	localparam logic [BYTE_W-1:0] RESP_LEN = 8'd2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_READ_OP  = 3'd0,
		CFG_WRITE_OP = 3'd1,
		CFG_ACK_OP   = 3'd2,
		CFG_NACK_OP  = 3'd3,
		CFG_NOP_OP   = 3'd4,
		CFG_SUM_ERR  = 3'd5,
		CFG_CMD_ERR  = 3'd6
	} cfg_reg_t;

	// byte slots of a response frame
	typedef enum logic [2:0] {
		RP_CMD  = 3'd0,
		RP_LEN  = 3'd1,
		RP_ADDR = 3'd2,
		RP_DATA = 3'd3,
		RP_SUM  = 3'd4
	} resp_pos_t;

endpackage

// ===== hw/rtl/rpr_if.sv =====
interface rpr_rx_if;
	import rpr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rpr_tx_if;
	import rpr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] tx_byte;
	logic              frame_end;
	logic              nop_seen;

	modport source (output valid, output tx_byte, output frame_end, output nop_seen,
		input ready);
	modport sink (input valid, input tx_byte, input frame_end, input nop_seen,
		output ready);
endinterface

// ===== hw/rtl/register_packet_responder.sv =====
// Byte-stream register responder. Frames arrive on rx as command, length, payload
// and checksum bytes, with the 8-bit sum of the whole frame wrapping to zero. Read
// and write commands act on a 256-byte register file held in a single-port-write
// RAM and are answered on tx with a five-byte ACK (ack opcode, 2, address, data,
// checksum); a bad checksum or unknown command gets a five-byte NACK carrying the
// matching error code. ACK, NACK and NOP frames get no answer; a good NOP sets the
// sticky nop_seen flag. Command, length and payload bytes are taken one per cycle.
// The checksum byte of a frame is taken only when the response path is empty: a
// response passes through the RAM read stage and is then sent on tx, so with tx
// always ready back-to-back minimum frames of three bytes are held back at their
// checksum byte, and frames of seven bytes or more run at one byte per cycle.
// The user writes opcodes and error codes over the cfg port only while the block
// is idle; the block itself does not enforce this. No clearing pass is needed
// after reset, a valid bit per register file entry stands in for the cleared RAM.
module register_packet_responder
	import rpr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	rpr_rx_if.sink               rx,
	rpr_tx_if.source             tx,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	// configuration
	logic [BYTE_W-1:0] read_op_q, write_op_q, ack_op_q, nack_op_q, nop_op_q;
	logic [BYTE_W-1:0] sum_err_q, cmd_err_q;

	// receive frame state
	logic [8:0]        pos_q;
	logic [BYTE_W-1:0] cmd_q, len_q, fp_q, sp_q, sum_q;
	logic              nop_q;
	logic              rf_valid_q [REG_COUNT];

	// ram read stage
	logic              valid_s1;
	logic [BYTE_W-1:0] cmd_s1, addr_s1, data_s1;
	logic              use_ram_s1, inrange_s1, rvalid_s1, nop_s1;

	// response buffer
	logic              resp_busy_q;
	resp_pos_t         resp_pos_q;
	logic [BYTE_W-1:0] resp_cmd_q, resp_addr_q, resp_data_q, resp_sum_q;
	logic              resp_nop_q;

	logic              is_last, rx_acc, end_acc, fp_inrange;
	logic [BYTE_W-1:0] sum_next, rd_data;
	logic              dec_emit, dec_wr, dec_use_ram, dec_nop;
	logic [BYTE_W-1:0] dec_cmd, dec_addr, dec_data;
	logic [RF_AW-1:0]  rf_idx;
	logic [BYTE_W-1:0] ram_rdata;

	// frame end detection and input handshake
	always_comb begin
		is_last    = (pos_q >= 9'd2) && (pos_q >= ({1'b0, len_q} + 9'd2));
		rx.ready   = !is_last || (!valid_s1 && !resp_busy_q);
		rx_acc     = rx.valid && rx.ready;
		end_acc    = rx_acc && is_last;
		sum_next   = sum_q + rx.rx_byte;
		fp_inrange = {1'b0, fp_q} < 9'(REG_COUNT);
		rf_idx     = fp_q[RF_AW-1:0];
	end

	// command decode at the checksum byte, first match wins
	always_comb begin
		dec_emit    = 1'b0;
		dec_wr      = 1'b0;
		dec_use_ram = 1'b0;
		dec_nop     = 1'b0;
		dec_cmd     = nack_op_q;
		dec_addr    = '0;
		dec_data    = '0;
		priority if (sum_next != '0) begin
			dec_emit = 1'b1;
			dec_data = sum_err_q;
		end else if (cmd_q == read_op_q) begin
			dec_emit    = 1'b1;
			dec_use_ram = 1'b1;
			dec_cmd     = ack_op_q;
			dec_addr    = fp_q;
		end else if (cmd_q == write_op_q) begin
			dec_emit = 1'b1;
			dec_wr   = fp_inrange;
			dec_cmd  = ack_op_q;
			dec_addr = fp_q;
			dec_data = fp_inrange ? sp_q : '0;
		end else if ((cmd_q == ack_op_q) || (cmd_q == nack_op_q)) begin
			dec_emit = 1'b0;
		end else if (cmd_q == nop_op_q) begin
			dec_nop = 1'b1;
		end else begin
			dec_emit = 1'b1;
			dec_data = cmd_err_q;
		end
	end

	// register file storage
	rpr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(REG_COUNT)
	) u_rf (
		.clk  (clk),
		.we   (end_acc && dec_wr),
		.waddr(rf_idx),
		.wdata(sp_q),
		.re   (end_acc),
		.raddr(rf_idx),
		.rdata(ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_op_q   <= 8'd0;
			write_op_q  <= 8'd1;
			ack_op_q    <= 8'd2;
			nack_op_q   <= 8'd3;
			nop_op_q    <= 8'd4;
			sum_err_q   <= 8'd1;
			cmd_err_q   <= 8'd2;
			pos_q       <= '0;
			nop_q       <= 1'b0;
			valid_s1    <= 1'b0;
			resp_busy_q <= 1'b0;
			resp_pos_q  <= RP_CMD;
			for (int i = 0; i < REG_COUNT; i++) begin
				rf_valid_q[i] <= 1'b0;
			end
		end else begin
			// configuration writes
			if (cfg_write_en) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_READ_OP:  read_op_q  <= cfg_data;
					CFG_WRITE_OP: write_op_q <= cfg_data;
					CFG_ACK_OP:   ack_op_q   <= cfg_data;
					CFG_NACK_OP:  nack_op_q  <= cfg_data;
					CFG_NOP_OP:   nop_op_q   <= cfg_data;
					CFG_SUM_ERR:  sum_err_q  <= cfg_data;
					CFG_CMD_ERR:  cmd_err_q  <= cfg_data;
					default: ;
				endcase
			end

			// byte position
			if (rx_acc) begin
				if (is_last) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 9'd1;
				end
			end

			if (end_acc && dec_nop) begin
				nop_q <= 1'b1;
			end
			if (end_acc && dec_wr) begin
				rf_valid_q[rf_idx] <= 1'b1;
			end

			valid_s1 <= end_acc && dec_emit;

			// response buffer load and drain
			if (valid_s1) begin
				resp_busy_q <= 1'b1;
				resp_pos_q  <= RP_CMD;
			end else if (tx.valid && tx.ready) begin
				if (resp_pos_q == RP_SUM) begin
					resp_busy_q <= 1'b0;
				end else begin
					resp_pos_q <= resp_pos_t'(resp_pos_q + 3'd1);
				end
			end
		end
	end

	// frame fields and running sum
	always_ff @(posedge clk) begin
		if (rx_acc) begin
			if (pos_q == 9'd0) begin
				cmd_q <= rx.rx_byte;
				sum_q <= rx.rx_byte;
				fp_q  <= '0;
				sp_q  <= '0;
			end else if (pos_q == 9'd1) begin
				len_q <= rx.rx_byte;
				sum_q <= sum_next;
			end else if (!is_last) begin
				if (pos_q == 9'd2) begin
					fp_q <= rx.rx_byte;
				end
				if (pos_q == 9'd3) begin
					sp_q <= rx.rx_byte;
				end
				sum_q <= sum_next;
			end else begin
				sum_q <= '0;
			end
		end
	end

	// ram read stage payload
	always_ff @(posedge clk) begin
		if (end_acc) begin
			cmd_s1     <= dec_cmd;
			addr_s1    <= dec_addr;
			data_s1    <= dec_data;
			use_ram_s1 <= dec_use_ram;
			inrange_s1 <= fp_inrange;
			rvalid_s1  <= fp_inrange && rf_valid_q[rf_idx];
			nop_s1     <= nop_q;
		end
	end

	// register data, unwritten or out of range entries read zero
	always_comb begin
		if (use_ram_s1) begin
			rd_data = (inrange_s1 && rvalid_s1) ? ram_rdata : '0;
		end else begin
			rd_data = data_s1;
		end
	end

	// response buffer payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			resp_cmd_q  <= cmd_s1;
			resp_addr_q <= addr_s1;
			resp_data_q <= rd_data;
			resp_sum_q  <= 8'd0 - (cmd_s1 + RESP_LEN + addr_s1 + rd_data);
			resp_nop_q  <= nop_s1;
		end
	end

	// output byte select
	always_comb begin
		tx.valid     = resp_busy_q;
		tx.frame_end = (resp_pos_q == RP_SUM);
		tx.nop_seen  = resp_nop_q;
		unique case (resp_pos_q)
			RP_CMD:  tx.tx_byte = resp_cmd_q;
			RP_LEN:  tx.tx_byte = RESP_LEN;
			RP_ADDR: tx.tx_byte = resp_addr_q;
			RP_DATA: tx.tx_byte = resp_data_q;
			RP_SUM:  tx.tx_byte = resp_sum_q;
			default: tx.tx_byte = '0;
		endcase
	end

endmodule

// ===== hw/rtl/rpr_ram.sv =====
module rpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/rpr_checker.sv =====
module rpr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] tx_byte,
	input logic       frame_end,
	input logic       nop_seen
);

	// a stalled response byte holds
	assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte))
		else $error("stalled tx item changed");

	// response bytes follow each other with no gap
	assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && !frame_end |=> tx_valid && $stable(nop_seen))
		else $error("gap or flag change inside a response");

	// a finished response is never followed at once by another
	assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && frame_end |=> !tx_valid)
		else $error("response started without a read stage cycle");

	// input stalls only while a response is on its way
	assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> tx_valid || $past(rx_valid && rx_ready))
		else $error("rx stalled with no response pending");

endmodule

bind register_packet_responder rpr_checker u_rpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rx_valid (rx.valid),
	.rx_ready (rx.ready),
	.tx_valid (tx.valid),
	.tx_ready (tx.ready),
	.tx_byte  (tx.tx_byte),
	.frame_end(tx.frame_end),
	.nop_seen (tx.nop_seen)
);
